// ===== hdl/ppz_pkg.sv =====
// Shared types, constants and helpers for the perspective point plotter.
package ppz_pkg;

	localparam int SCREEN_WIDTH  = 160;
	localparam int SCREEN_HEIGHT = 44;
	localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int ADDR_W        = $clog2(CELL_COUNT);
	localparam int COL_W         = $clog2(SCREEN_WIDTH);
	localparam int ROW_W         = $clog2(SCREEN_HEIGHT);

	localparam int IDX_W     = 13;
	localparam int COORD_W   = 24;
	localparam int TRIG_W    = 16;
	localparam int SCALE_W   = 16;
	localparam int RECIP_W   = 16;
	localparam int GLYPH_W   = 8;
	localparam int CFG_IDX_W = 3;

	// multiplier operand and result widths
	localparam int MA_W   = 34;
	localparam int MB_W   = 25;
	localparam int PROD_W = MA_W + MB_W;
	localparam int SUM_W  = PROD_W + 1;

	localparam int TRIG_SHIFT = 14;
	localparam int FRAC_SHIFT = 28;
	localparam int NEAR_LIMIT = 25;
	localparam int DIV_STEPS  = RECIP_W;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [GLYPH_W-1:0] GLYPH_SPACE = 8'd32;

	localparam logic MODE_PLOT = 1'b0;
	localparam logic MODE_READ = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Z     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_YAW_COSINE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_YAW_SINE     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_COSINE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_SINE   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_PROJ_SCALE   = 3'd7;

	typedef struct packed {
		logic                 mode;
		logic [COORD_W-1:0]   point_x;
		logic [COORD_W-1:0]   point_y;
		logic [COORD_W-1:0]   point_z;
		logic [GLYPH_W-1:0]   glyph;
		logic [IDX_W-1:0]     read_index;
	} in_item_t;

	typedef struct packed {
		logic                 on_screen;
		logic                 cell_written;
		logic [IDX_W-1:0]     cell_index;
		logic [GLYPH_W-1:0]   cell_glyph;
	} out_item_t;

	typedef struct packed {
		logic [COORD_W-1:0]   camera_x;
		logic [COORD_W-1:0]   camera_y;
		logic [COORD_W-1:0]   camera_z;
		logic [TRIG_W-1:0]    yaw_cosine;
		logic [TRIG_W-1:0]    yaw_sine;
		logic [TRIG_W-1:0]    pitch_cosine;
		logic [TRIG_W-1:0]    pitch_sine;
		logic [SCALE_W-1:0]   projection_scale;
	} cfg_t;

	// classified item handed from the front to the back
	typedef struct packed {
		logic                 mode;
		logic                 on;
		logic [IDX_W-1:0]     idx;
		logic [GLYPH_W-1:0]   glyph;
		logic [RECIP_W-1:0]   recip;
	} qitem_t;

	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
		lo = -hi - SUM_W'(1);
		if (v > hi)
			return hi[COORD_W-1:0];
		else if (v < lo)
			return lo[COORD_W-1:0];
		else
			return v[COORD_W-1:0];
	endfunction

endpackage

// ===== hdl/perspective_point_plotter_zbuffer.sv =====
// Top level: configuration registers, front end, item queue and frame store back end.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------
//  command  | start / busy           | cmd (in_item_t)
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//  result   | done (one-cycle strobe)| result (out_item_t)
//
// A plot item keeps the front end busy for 8 rotation steps on the shared
// multiplier, 16 steps of bit-serial reciprocal division, 3 projection steps
// and 1 push step. A point behind or too near skips division and projection.
// A read item goes straight to the push step.
// The push waits while the queue is full. The back end pops an item only while
// idle; an item that needs the frame store is held for a depth check first.
// After reset the frame store is cleared one cell a cycle, all 7040 cells, with busy high.
// The result strobe cannot be held off; the queue absorbs back-end memory cycles.
module perspective_point_plotter_zbuffer import ppz_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  in_item_t             cmd,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]   cfg_data,
	output logic                 done,
	output out_item_t            result
);

	cfg_t   cfg_q;
	logic   front_busy, clearing, go;
	logic   push, full, pop, empty;
	qitem_t push_item, head;

	assign cfg_ready = 1'b1;
	assign busy      = front_busy || clearing;
	assign go        = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.camera_x         <= COORD_W'(0);
			cfg_q.camera_y         <= COORD_W'(7680);
			cfg_q.camera_z         <= COORD_W'(-17920);
			cfg_q.yaw_cosine       <= TRIG_W'(16384);
			cfg_q.yaw_sine         <= TRIG_W'(0);
			cfg_q.pitch_cosine     <= TRIG_W'(14379);
			cfg_q.pitch_sine       <= TRIG_W'(-7855);
			cfg_q.projection_scale <= SCALE_W'(10240);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CAMERA_X:     cfg_q.camera_x         <= cfg_data;
				REG_CAMERA_Y:     cfg_q.camera_y         <= cfg_data;
				REG_CAMERA_Z:     cfg_q.camera_z         <= cfg_data;
				REG_YAW_COSINE:   cfg_q.yaw_cosine       <= cfg_data[TRIG_W-1:0];
				REG_YAW_SINE:     cfg_q.yaw_sine         <= cfg_data[TRIG_W-1:0];
				REG_PITCH_COSINE: cfg_q.pitch_cosine     <= cfg_data[TRIG_W-1:0];
				REG_PITCH_SINE:   cfg_q.pitch_sine       <= cfg_data[TRIG_W-1:0];
				REG_PROJ_SCALE:   cfg_q.projection_scale <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	ppz_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.cmd       (cmd),
		.cfg       (cfg_q),
		.busy      (front_busy),
		.push      (push),
		.push_item (push_item),
		.full      (full)
	);

	ppz_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	ppz_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.head     (head),
		.pop      (pop),
		.clearing (clearing),
		.done     (done),
		.result   (result)
	);

endmodule

// ===== hdl/ppz_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module ppz_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ===== hdl/ppz_front.sv =====
// Front end: accepts items, rotates, divides and projects plot points.
module ppz_front import ppz_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     go,
	input  in_item_t cmd,
	input  cfg_t     cfg,
	output logic     busy,
	output logic     push,
	output qitem_t   push_item,
	input  logic     full
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ROT  = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_PROJ = 3'd3;
	localparam logic [2:0] S_PUSH = 3'd4;

	logic [2:0]                  state_q;
	logic [3:0]                  step_q;
	logic signed [COORD_W-1:0]   cx_q, cy_q, cz_q, tx_q, tz_q, ty_q, fz_q;
	logic signed [PROD_W-1:0]    acc_q;
	logic [COORD_W:0]            rem_q;
	logic [RECIP_W-1:0]          quo_q;
	logic signed [SUM_W-1:0]     xs_q, ys_q;
	logic                        mode_q, near_q;
	logic [GLYPH_W-1:0]          glyph_q;
	logic [IDX_W-1:0]            idx_q;

	logic signed [MA_W-1:0]      ma;
	logic signed [MB_W-1:0]      mb;
	logic signed [PROD_W-1:0]    prod;
	logic signed [SUM_W-1:0]     rsum;
	logic signed [COORD_W-1:0]   rot_val;
	logic [COORD_W:0]            rem2;
	logic                        rem_ge;
	logic signed [COORD_W:0]     dx, dy, dz;
	logic signed [SUM_W-1:0]     col_full, row_full;
	logic                        col_ok, row_ok, hit;
	logic [COL_W-1:0]            col;
	logic [ROW_W-1:0]            row;

	localparam logic signed [SUM_W-1:0] FRAC_ONE = SUM_W'(64'sd1 <<< FRAC_SHIFT);

	// shared multiplier operand selection
	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			S_ROT: begin
				case (step_q[2:0])
					3'd0: begin ma = MA_W'(cx_q); mb = MB_W'($signed(cfg.yaw_cosine)); end
					3'd1: begin ma = MA_W'(cz_q); mb = MB_W'($signed(cfg.yaw_sine)); end
					3'd2: begin ma = MA_W'(cx_q); mb = MB_W'($signed(cfg.yaw_sine)); end
					3'd3: begin ma = MA_W'(cz_q); mb = MB_W'($signed(cfg.yaw_cosine)); end
					3'd4: begin ma = MA_W'(cy_q); mb = MB_W'($signed(cfg.pitch_cosine)); end
					3'd5: begin ma = MA_W'(tz_q); mb = MB_W'($signed(cfg.pitch_sine)); end
					3'd6: begin ma = MA_W'(cy_q); mb = MB_W'($signed(cfg.pitch_sine)); end
					default: begin ma = MA_W'(tz_q); mb = MB_W'($signed(cfg.pitch_cosine)); end
				endcase
			end
			S_PROJ: begin
				case (step_q[1:0])
					2'd0: begin
						ma = $signed({{(MA_W-SCALE_W){1'b0}}, cfg.projection_scale});
						mb = $signed({{(MB_W-RECIP_W){1'b0}}, quo_q});
					end
					2'd1: begin ma = $signed({2'b00, acc_q[MA_W-3:0]}); mb = MB_W'(tx_q); end
					default: begin ma = $signed({2'b00, acc_q[MA_W-3:0]}); mb = MB_W'(ty_q); end
				endcase
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign prod    = ma * mb;
	// odd rotation steps: add when step bit 1 is set, otherwise subtract
	assign rsum    = step_q[1] ? (SUM_W'(acc_q) + SUM_W'(prod)) : (SUM_W'(acc_q) - SUM_W'(prod));
	assign rot_val = sat_coord(rsum >>> TRIG_SHIFT);

	assign rem2   = {rem_q[COORD_W-1:0], 1'b0};
	assign rem_ge = rem2 >= {1'b0, fz_q};

	assign dx = $signed({cmd.point_x[COORD_W-1], cmd.point_x})
		- $signed({cfg.camera_x[COORD_W-1], cfg.camera_x});
	assign dy = $signed({cmd.point_y[COORD_W-1], cmd.point_y})
		- $signed({cfg.camera_y[COORD_W-1], cfg.camera_y});
	assign dz = $signed({cmd.point_z[COORD_W-1], cmd.point_z})
		- $signed({cfg.camera_z[COORD_W-1], cfg.camera_z});

	// truncation toward zero: anything above minus one cell lands in column zero
	assign col_full = xs_q >>> FRAC_SHIFT;
	assign row_full = ys_q >>> FRAC_SHIFT;
	assign col_ok   = (xs_q > -FRAC_ONE) && (col_full < SUM_W'(SCREEN_WIDTH));
	assign row_ok   = (ys_q > -FRAC_ONE) && (row_full < SUM_W'(SCREEN_HEIGHT));
	assign col      = xs_q[SUM_W-1] ? '0 : col_full[COL_W-1:0];
	assign row      = ys_q[SUM_W-1] ? '0 : row_full[ROW_W-1:0];
	assign hit      = (mode_q == MODE_PLOT) && near_q && col_ok && row_ok;

	always_comb begin
		push_item.mode  = mode_q;
		push_item.on    = hit;
		push_item.glyph = glyph_q;
		push_item.recip = quo_q;
		if (mode_q == MODE_READ)
			push_item.idx = idx_q;
		else if (hit)
			push_item.idx = IDX_W'(row * SCREEN_WIDTH + col);
		else
			push_item.idx = '0;
	end

	assign push = (state_q == S_PUSH) && !full;
	assign busy = state_q != S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					step_q <= '0;
					if (go)
						state_q <= (cmd.mode == MODE_READ) ? S_PUSH : S_ROT;
				end
				S_ROT: begin
					step_q <= step_q + 4'd1;
					if (step_q[2:0] == 3'd7) begin
						step_q  <= '0;
						state_q <= (rot_val > COORD_W'(NEAR_LIMIT)) ? S_DIV : S_PUSH;
					end
				end
				S_DIV: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'(DIV_STEPS - 1)) begin
						step_q  <= '0;
						state_q <= S_PROJ;
					end
				end
				S_PROJ: begin
					step_q <= step_q + 4'd1;
					if (step_q[1:0] == 2'd2)
						state_q <= S_PUSH;
				end
				S_PUSH: begin
					if (!full)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (go) begin
					mode_q  <= cmd.mode;
					glyph_q <= cmd.glyph;
					idx_q   <= cmd.read_index;
					near_q  <= 1'b0;
					cx_q    <= sat_coord(SUM_W'(dx));
					cy_q    <= sat_coord(SUM_W'(dy));
					cz_q    <= sat_coord(SUM_W'(dz));
				end
			end
			S_ROT: begin
				case (step_q[2:0])
					3'd1: tx_q <= rot_val;
					3'd3: tz_q <= rot_val;
					3'd5: ty_q <= rot_val;
					3'd7: begin
						fz_q   <= rot_val;
						near_q <= rot_val > COORD_W'(NEAR_LIMIT);
						// bits above the top quotient bit leave sixteen, below any kept depth
						rem_q  <= (COORD_W+1)'(1 << (20 - RECIP_W));
						quo_q  <= '0;
					end
					default: acc_q <= prod;
				endcase
			end
			S_DIV: begin
				rem_q <= rem_ge ? (rem2 - {1'b0, fz_q}) : rem2;
				quo_q <= {quo_q[RECIP_W-2:0], rem_ge};
			end
			S_PROJ: begin
				case (step_q[1:0])
					2'd0: acc_q <= prod;
					2'd1: xs_q <= (SUM_W'(SCREEN_WIDTH) <<< (FRAC_SHIFT - 1)) + (SUM_W'(prod) <<< 1);
					default: ys_q <= (SUM_W'(SCREEN_HEIGHT) <<< (FRAC_SHIFT - 1)) - SUM_W'(prod);
				endcase
			end
			default: ;
		endcase
	end

endmodule

// ===== hdl/ppz_queue.sv =====
// Short queue of classified items between the front and the back.
module ppz_queue import ppz_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  qitem_t push_item,
	output logic   full,
	input  logic   pop,
	output qitem_t head,
	output logic   empty
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	qitem_t            items_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_q, rd_q;
	logic [PTR_W:0]    count_q;

	assign full  = count_q == (PTR_W+1)'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head  = items_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			if (pop)
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			count_q <= count_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			items_q[wr_q] <= push_item;
	end

endmodule

// ===== hdl/ppz_back.sv =====
// Back end: clears the frame store, depth-tests plots and serves reads, which blank the cell they read.
module ppz_back import ppz_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      empty,
	input  qitem_t    head,
	output logic      pop,
	output logic      clearing,
	output logic      done,
	output out_item_t result
);

	localparam logic B_IDLE  = 1'b0;
	localparam logic B_CHECK = 1'b1;
	localparam int   DATA_W  = GLYPH_W + RECIP_W;

	logic              bstate_q;
	logic              clearing_q;
	logic [ADDR_W-1:0] clr_q;
	qitem_t            cur_q;
	logic              done_q;
	out_item_t         res_q;

	logic              need_mem;
	logic              we, deeper;
	logic [ADDR_W-1:0] waddr;
	logic [DATA_W-1:0] wdata, rdata;
	logic [GLYPH_W-1:0] old_glyph;
	logic [RECIP_W-1:0] old_depth;

	ppz_ram #(.WIDTH(DATA_W), .DEPTH(CELL_COUNT)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (pop),
		.raddr (head.idx[ADDR_W-1:0]),
		.rdata (rdata)
	);

	assign {old_glyph, old_depth} = rdata;
	assign deeper   = cur_q.recip > old_depth;
	assign need_mem = (head.mode == MODE_READ) ? (head.idx < IDX_W'(CELL_COUNT)) : head.on;
	assign pop      = !clearing_q && (bstate_q == B_IDLE) && !empty;

	always_comb begin
		we    = 1'b0;
		waddr = cur_q.idx[ADDR_W-1:0];
		wdata = {GLYPH_SPACE, {RECIP_W{1'b0}}};
		if (clearing_q) begin
			we    = 1'b1;
			waddr = clr_q;
		end else if (bstate_q == B_CHECK) begin
			if (cur_q.mode == MODE_READ) begin
				we = 1'b1;
			end else begin
				we    = deeper;
				wdata = {cur_q.glyph, cur_q.recip};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bstate_q   <= B_IDLE;
			clearing_q <= 1'b1;
			clr_q      <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (clearing_q) begin
				clr_q <= clr_q + ADDR_W'(1);
				if (clr_q == ADDR_W'(CELL_COUNT - 1))
					clearing_q <= 1'b0;
			end
			case (bstate_q)
				B_IDLE: begin
					if (pop) begin
						if (need_mem)
							bstate_q <= B_CHECK;
						else
							done_q <= 1'b1;
					end
				end
				B_CHECK: begin
					bstate_q <= B_IDLE;
					done_q   <= 1'b1;
				end
				default: bstate_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (bstate_q == B_IDLE) begin
			if (pop) begin
				cur_q              <= head;
				res_q.on_screen    <= 1'b0;
				res_q.cell_written <= 1'b0;
				res_q.cell_index   <= head.idx;
				res_q.cell_glyph   <= '0;
			end
		end else begin
			res_q.cell_index <= cur_q.idx;
			if (cur_q.mode == MODE_READ) begin
				res_q.on_screen    <= 1'b0;
				res_q.cell_written <= 1'b0;
				res_q.cell_glyph   <= old_glyph;
			end else begin
				res_q.on_screen    <= 1'b1;
				res_q.cell_written <= deeper;
				res_q.cell_glyph   <= '0;
			end
		end
	end

	assign clearing = clearing_q;
	assign done     = done_q;
	assign result   = res_q;

	a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !done_q)
		else $error("result issued during clearing pass");

	a_written_implies_on: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && res_q.cell_written |-> res_q.on_screen)
		else $error("cell written for a point off screen");

	a_check_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		bstate_q == B_CHECK |=> bstate_q == B_IDLE && done_q)
		else $error("depth check did not complete in one cycle");

	a_no_pop_in_check: assert property (@(posedge clk) disable iff (!arst_n)
		bstate_q == B_CHECK |-> !pop)
		else $error("queue popped while a cell is being checked");

endmodule
